@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fpr_pkg.sv @@
// shared constants for the fifo page replacement block
`timescale 1ns / 1ps

package fpr_pkg;

  // frame count register
  localparam int unsigned CfgW        = 12;
  localparam int unsigned FramesReset = 4;

  // running totals
  localparam int unsigned TotalW = 32;

  // parameter defaults
  localparam int unsigned MaxFramesDef = 2048;
  localparam int unsigned PageBitsDef  = 20;

endpackage

@@ rtl/core/fifo_page_replacement_top.sv @@
// fifo page replacement unit: frame store, linear search and ring eviction
`timescale 1ns / 1ps

// FIFO page replacement unit
//
// Request channel: drive page_number_i and raise start; the item is taken at
// the clock edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Result channel: done_o is high for exactly one cycle with hit_o,
// evicted_valid_o, evicted_page_o, fault_total_o and request_total_o. The
// receiver cannot stall; results must be captured in that cycle.
// Config channel: cfg_valid_i/cfg_ready_o write the frame count register
// (0 acts as 1, above MAX_FRAMES acts as MAX_FRAMES); write it only while idle.
// Timing: one frame-store read port scans the resident frames one per cycle.
// On a miss that fills a free frame, done_o rises once every resident frame
// has been searched (the search is empty when none is resident); a replacement
// adds the victim read in StVictim, and a hit in frame k ends the search at
// frame k. busy drops the cycle after done_o.
// Reset clears the fill count, oldest pointer and both totals and sets the
// frame count to 4. The frame store is not cleared; no unwritten slot is read.
module fifo_page_replacement_top
  import fpr_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MaxFramesDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_number_i,
  // config channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgW-1:0]      cfg_data_i,
  // result channel
  output logic                 done_o,
  output logic                 hit_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [TotalW-1:0]    fault_total_o,
  output logic [TotalW-1:0]    request_total_o
);

  localparam int unsigned SlotW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSearch = 4'b0010,
    StVictim = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]      frames_q;
  logic [CntW-1:0]      filled_q, filled_d;
  logic [SlotW-1:0]     oldest_q, oldest_d;
  logic [TotalW-1:0]    fault_q, fault_d;
  logic [TotalW-1:0]    req_q, req_d;
  logic [CntW-1:0]      n_q, n_d;
  logic [CntW-1:0]      live_q, live_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [SlotW-1:0]     vic_slot_q, vic_slot_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 rd_vld_q;
  logic                 hit_q, hit_d;
  logic                 evict_q, evict_d;
  logic [PAGE_BITS-1:0] victim_q, victim_d;

  logic                 accept;
  logic [CntW-1:0]      eff_n;
  logic                 issue;
  logic                 mem_re, mem_we;
  logic [SlotW-1:0]     mem_raddr, mem_waddr;
  logic [PAGE_BITS-1:0] rd_data_q;
  logic [SlotW-1:0]     wrap_slot;
  logic [CntW-1:0]      slot_inc;

  logic [PAGE_BITS-1:0] frame_mem [MAX_FRAMES];

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // effective frame count from the register
  always_comb begin
    if (frames_q == '0) begin
      eff_n = CntW'(1);
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      eff_n = CntW'(MAX_FRAMES);
    end else begin
      eff_n = CntW'(frames_q);
    end
  end

  // one read per cycle while scanning resident frames
  assign issue = (state_q == StSearch) && (idx_q < live_q);

  // oldest slot restarted if the frame count shrank, and its successor
  assign wrap_slot = (CntW'(oldest_q) >= n_q) ? '0 : oldest_q;
  assign slot_inc  = CntW'(vic_slot_q) + CntW'(1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    filled_d   = filled_q;
    oldest_d   = oldest_q;
    fault_d    = fault_q;
    req_d      = req_q;
    n_d        = n_q;
    live_d     = live_q;
    idx_d      = idx_q;
    vic_slot_d = vic_slot_q;
    page_d     = page_q;
    hit_d      = hit_q;
    evict_d    = evict_q;
    victim_d   = victim_q;
    mem_re     = 1'b0;
    mem_raddr  = idx_q[SlotW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = filled_q[SlotW-1:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          page_d   = page_number_i;
          req_d    = req_q + TotalW'(1);
          n_d      = eff_n;
          live_d   = (filled_q < eff_n) ? filled_q : eff_n;
          idx_d    = '0;
          hit_d    = 1'b0;
          evict_d  = 1'b0;
          victim_d = '0;
          state_d  = StSearch;
        end
      end
      StSearch: begin
        if (issue) begin
          mem_re = 1'b1;
          idx_d  = idx_q + CntW'(1);
        end
        if (rd_vld_q && (rd_data_q == page_q)) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else if (!issue && !rd_vld_q) begin
          if (filled_q < n_q) begin
            // free frame left: fill the next slot
            mem_we   = 1'b1;
            filled_d = filled_q + CntW'(1);
            state_d  = StDone;
          end else begin
            // full: fetch the oldest resident page
            mem_re     = 1'b1;
            mem_raddr  = wrap_slot;
            vic_slot_d = wrap_slot;
            state_d    = StVictim;
          end
        end
      end
      StVictim: begin
        mem_we    = 1'b1;
        mem_waddr = vic_slot_q;
        victim_d  = rd_data_q;
        evict_d   = 1'b1;
        fault_d   = fault_q + TotalW'(1);
        oldest_d  = (slot_inc >= n_q) ? '0 : slot_inc[SlotW-1:0];
        state_d   = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      frames_q <= CfgW'(FramesReset);
      filled_q <= '0;
      oldest_q <= '0;
      fault_q  <= '0;
      req_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      oldest_q <= oldest_d;
      fault_q  <= fault_d;
      req_q    <= req_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        frames_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    live_q     <= live_d;
    vic_slot_q <= vic_slot_d;
    page_q     <= page_d;
    hit_q      <= hit_d;
    evict_q    <= evict_d;
    victim_q   <= victim_d;
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= page_q;
    end
    if (mem_re) begin
      rd_data_q <= frame_mem[mem_raddr];
    end
  end

  // result ports
  assign done_o          = (state_q == StDone);
  assign hit_o           = hit_q;
  assign evicted_valid_o = evict_q;
  assign evicted_page_o  = victim_q;
  assign fault_total_o   = fault_q;
  assign request_total_o = req_q;

endmodule

@@ rtl/core/fpr_checker.sv @@
// port-level checks for the fifo page replacement block, bound to the top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpr_checker
  import fpr_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PageBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic                 hit_o,
  input logic                 evicted_valid_o,
  input logic [PAGE_BITS-1:0] evicted_page_o,
  input logic [TotalW-1:0]    request_total_o
);

  // a result only appears inside an item's busy window
  `ASSERT_IMP(a_done_busy, done_o, busy, "result strobe while not busy")

  // an accepted item makes the block busy and bumps the request total
  `ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")
  `ASSERT_NXT(a_req_count, start && !busy,
              request_total_o == $past(request_total_o) + TotalW'(1),
              "request total did not advance")

  // the block frees up right after the result
  `ASSERT_NXT(a_done_free, done_o, !busy, "still busy after result")

  // a hit never evicts, and no eviction reports a page
  `ASSERT_IMP(a_result_clean, done_o,
              !(hit_o && evicted_valid_o) && (evicted_valid_o || evicted_page_o == '0),
              "inconsistent result fields")

endmodule

bind fifo_page_replacement_top fpr_checker #(
  .PAGE_BITS(PAGE_BITS)
) u_fpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .hit_o          (hit_o),
  .evicted_valid_o(evicted_valid_o),
  .evicted_page_o (evicted_page_o),
  .request_total_o(request_total_o)
);
